// ----- design/scs1_pkg.sv -----
package scs1_pkg;

    localparam int unsigned SCAN_W      = 8;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned MAP_ENTRIES = 59;

    localparam logic [7:0] PREFIX_CODE = 8'hE0;
    localparam logic [6:0] LSHIFT_CODE = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE = 7'h36;
    localparam logic [6:0] CTRL_CODE   = 7'h1D;
    localparam logic [6:0] CTRL_MASK   = 7'h1F;
    localparam logic [6:0] CASE_BIT    = 7'h20;
    localparam logic [6:0] LOWER_A     = 7'h61;
    localparam logic [6:0] LOWER_Z     = 7'h7A;

    typedef logic [SCAN_W-1:0] t_scan;
    typedef logic [CHAR_W-1:0] t_char;

    // plain key map, entries past the table read as zero
    function automatic t_char plain_map(input logic [6:0] code);
        t_char ch;
        case (code)
            7'h01: ch = 7'h1B;  7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;
            7'h0D: ch = 7'h3D;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;  7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
            7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;  7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;  7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;  7'h23: ch = 7'h68;  7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;
            7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
            7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
            7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;
            7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // shifted key map
    function automatic t_char shifted_map(input logic [6:0] code);
        t_char ch;
        case (code)
            7'h01: ch = 7'h1B;  7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;
            7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;
            7'h0D: ch = 7'h2B;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h51;
            7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;  7'h14: ch = 7'h54;
            7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
            7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;  7'h1C: ch = 7'h0A;
            7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;  7'h21: ch = 7'h46;
            7'h22: ch = 7'h47;  7'h23: ch = 7'h48;  7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;
            7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
            7'h2B: ch = 7'h7C;  7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
            7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;
            7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h37: ch = 7'h2A;
            7'h39: ch = 7'h20;
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/scs1_ifs.sv -----
interface scs1_scan_if
    import scs1_pkg::*;
;
    logic  valid;
    logic  ready;
    t_scan scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface scs1_char_if
    import scs1_pkg::*;
;
    logic  valid;
    logic  ready;
    t_char char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ----- design/scancode_set1_to_ascii_core.sv -----
// an accepted byte is held in the input register, and its character is then held in the result register
// throughput: one scancode byte per cycle while the receiver takes characters, set by the input and result registers
// a byte that gives no character leaves the input register without a result
// reset (synchronous, active low) clears shift, control and prefix flags
// and empties the input and result registers
module scancode_set1_to_ascii_core
    import scs1_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    scs1_scan_if.sink     i_scan,
    scs1_char_if.source   o_char
);

    logic  r_in_vld;
    t_scan r_in_byte;
    logic  r_out_vld;
    t_char r_out_char;
    logic  r_shift;
    logic  r_ctrl;
    logic  r_ext;

    logic       n_shift;
    logic       n_ctrl;
    logic       n_ext;
    logic       has_char;
    t_char      n_char;
    t_char      rom_char;
    t_char      folded;
    logic [6:0] code;
    logic       is_shift;
    logic       is_ctrl;
    logic       out_free;
    logic       advance;

    assign code     = r_in_byte[6:0];
    assign is_shift = !r_ext && (code == LSHIFT_CODE || code == RSHIFT_CODE);
    assign is_ctrl  = (code == CTRL_CODE);
    assign rom_char = r_shift ? shifted_map(code) : plain_map(code);
    assign folded   = rom_char | CASE_BIT;

    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_ext    = r_ext;
        has_char = 1'b0;
        n_char   = rom_char;
        if (r_in_byte == PREFIX_CODE) begin
            n_ext = 1'b1;
        end else if (r_in_byte[7]) begin
            if (is_shift) begin
                n_shift = 1'b0;
            end else if (is_ctrl) begin
                n_ctrl = 1'b0;
            end
            n_ext = 1'b0;
        end else if (is_shift) begin
            n_shift = 1'b1;
        end else if (is_ctrl) begin
            n_ctrl = 1'b1;
        end else if (r_ext) begin
            n_ext = 1'b0;
        end else if ({1'b0, code} < 8'(MAP_ENTRIES)) begin
            has_char = (rom_char != '0);
            if (r_ctrl && folded >= LOWER_A && folded <= LOWER_Z) begin
                n_char = rom_char & CTRL_MASK;
            end
        end
    end

    assign out_free     = !r_out_vld || o_char.ready;
    assign advance      = r_in_vld && (!has_char || out_free);
    assign i_scan.ready = !r_in_vld || advance;

    assign o_char.valid     = r_out_vld;
    assign o_char.char_code = r_out_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_shift   <= 1'b0;
            r_ctrl    <= 1'b0;
            r_ext     <= 1'b0;
        end else begin
            if (i_scan.ready) begin
                r_in_vld <= i_scan.valid;
            end
            if (advance) begin
                r_shift <= n_shift;
                r_ctrl  <= n_ctrl;
                r_ext   <= n_ext;
            end
            if (out_free) begin
                r_out_vld <= advance && has_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.ready && i_scan.valid) begin
            r_in_byte <= i_scan.scan_byte;
        end
        if (out_free && advance && has_char) begin
            r_out_char <= n_char;
        end
    end

endmodule

// ----- tb/sv/scancode_set1_to_ascii_core_tb.sv -----
`timescale 1ns / 1ps

package scs1_tb_pkg;
    import scs1_pkg::*;

    localparam int unsigned KEY_TAB_LEN = 59;
    localparam t_scan       BREAK_FLAG  = 8'h80;

    localparam t_char KEY_PLAIN [KEY_TAB_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    localparam t_char KEY_SHIFTED [KEY_TAB_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    class key_char_board;
        bit          shift_down;
        bit          ctrl_down;
        bit          e0_seen;
        t_char       char_q[$];
        int unsigned fail_cnt;

        function int unsigned pending();
            return char_q.size();
        endfunction

        // track modifier flags and queue the character a request produces
        function void note_request(t_scan b);
            logic [6:0] code;
            t_char      ch;
            t_char      folded;
            code = b[SCAN_W-2:0];
            if (b == PREFIX_CODE) begin
                e0_seen = 1'b1;
                return;
            end
            if ((b & BREAK_FLAG) != '0) begin
                if (!e0_seen && (code == LSHIFT_CODE || code == RSHIFT_CODE)) begin
                    shift_down = 1'b0;
                end else if (code == CTRL_CODE) begin
                    ctrl_down = 1'b0;
                end
                e0_seen = 1'b0;
                return;
            end
            if (!e0_seen && (code == LSHIFT_CODE || code == RSHIFT_CODE)) begin
                shift_down = 1'b1;
                return;
            end
            if (code == CTRL_CODE) begin
                ctrl_down = 1'b1;
                return;
            end
            if (e0_seen) begin
                e0_seen = 1'b0;
                return;
            end
            if (code >= MAP_ENTRIES) return;
            if (code < KEY_TAB_LEN) begin
                ch = shift_down ? KEY_SHIFTED[code] : KEY_PLAIN[code];
            end else begin
                ch = '0;
            end
            if (ch == '0) return;
            folded = ch | CASE_BIT;
            if (ctrl_down && folded >= LOWER_A && folded <= LOWER_Z) begin
                ch = ch & CTRL_MASK;
            end
            char_q.push_back(ch);
        endfunction

        function void check_char(t_char got);
            t_char want;
            if (char_q.size() == 0) begin
                $error("char_code: no character expected, actual 0x%02h", got);
                fail_cnt++;
                return;
            end
            want = char_q.pop_front();
            if (got !== want) begin
                $error("char_code: expected 0x%02h, actual 0x%02h", want, got);
                fail_cnt++;
            end
        endfunction
    endclass
endpackage

module scancode_set1_to_ascii_core_tb;
    import scs1_pkg::*;
    import scs1_tb_pkg::*;

    typedef enum {RX_FREE, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    scs1_scan_if scan_ch ();
    scs1_char_if char_ch ();

    key_char_board sb = new;

    t_scan       key_stream[$];
    int unsigned items_sent;
    int unsigned gap_max;
    int unsigned burst_max;
    t_rx_mode    rx_mode;
    int unsigned rx_hold;
    int unsigned rx_run;
    bit          rx_on;

    scancode_set1_to_ascii_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_ch),
        .o_char  (char_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("scancode_set1_to_ascii_core_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && scan_ch.valid && scan_ch.ready) sb.note_request(scan_ch.scan_byte);
        if (i_rst_n && char_ch.valid && char_ch.ready) sb.check_char(char_ch.char_code);
    end

    // receiver stall pattern, long hold-offs counted here
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            char_ch.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    char_ch.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    char_ch.ready <= ($urandom_range(0, 99) >= 35);
                end
                default: begin
                    if (rx_run == 0) begin
                        rx_on  = !rx_on;
                        rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end
                    rx_run = rx_run - 1;
                    char_ch.ready <= rx_on;
                end
            endcase
        end
    end

    task automatic send_byte(input t_scan b);
        scan_ch.valid     <= 1'b1;
        scan_ch.scan_byte <= b;
        do @(posedge i_clk); while (!scan_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int unsigned n);
        scan_ch.valid     <= 1'b0;
        scan_ch.scan_byte <= t_scan'($urandom_range(0, 255));
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_chars_done();
        idle_sender(0);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one keyboard event: taps, modifiers, extended keys and noise
    task automatic push_key_event();
        int unsigned pick;
        t_scan       code;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            code = t_scan'($urandom_range(0, 63));
            key_stream.push_back(code);
            if ($urandom_range(0, 3) != 0) key_stream.push_back(code | BREAK_FLAG);
        end else if (pick < 57) begin
            code = $urandom_range(0, 1) ? t_scan'(LSHIFT_CODE) : t_scan'(RSHIFT_CODE);
            key_stream.push_back($urandom_range(0, 1) ? code : (code | BREAK_FLAG));
        end else if (pick < 65) begin
            code = t_scan'(CTRL_CODE);
            key_stream.push_back($urandom_range(0, 1) ? code : (code | BREAK_FLAG));
        end else if (pick < 77) begin
            key_stream.push_back(PREFIX_CODE);
            if ($urandom_range(0, 3) == 0) begin
                code = t_scan'(CTRL_CODE);
                key_stream.push_back($urandom_range(0, 1) ? code : (code | BREAK_FLAG));
            end else begin
                key_stream.push_back(t_scan'($urandom_range(0, 255)));
            end
        end else if (pick < 90) begin
            key_stream.push_back(t_scan'($urandom_range(0, 255)));
        end else begin
            key_stream.push_back(t_scan'($urandom_range(0, 127)));
        end
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned stop_at;
        int unsigned burst;
        int unsigned gap;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            burst = $urandom_range(1, burst_max);
            repeat (burst) begin
                if (key_stream.size() == 0) push_key_event();
                send_byte(key_stream.pop_front());
            end
            gap = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
            if (gap != 0) idle_sender(gap);
        end
        while (key_stream.size() != 0) send_byte(key_stream.pop_front());
    endtask

    initial begin
        i_rst_n           = 1'b0;
        scan_ch.valid     = 1'b0;
        scan_ch.scan_byte = '0;
        char_ch.ready     = 1'b0;
        rx_mode           = RX_FREE;
        rx_hold           = 0;
        rx_run            = 0;
        rx_on             = 1'b0;
        items_sent        = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain, unmapped, out of map, shifted keys, control letters
        key_stream = '{8'h10, 8'h00, 8'h3A, 8'h7F, 8'h2A, 8'h35, 8'h10, 8'hAA,
                       8'h36, 8'h02, 8'hB6, 8'h1D, 8'h1E, 8'h2C, 8'h1A, 8'h9D};
        // extended control keeps the prefix, extended shift is ignored
        key_stream = {key_stream, 8'hE0, 8'h1D, 8'h10, 8'hE0, 8'h2A, 8'h10,
                      8'h2A, 8'hE0, 8'hAA, 8'h10, 8'hAA, 8'hE0, 8'h9D,
                      8'hFF, 8'h80, 8'h39, 8'h01};
        while (key_stream.size() != 0) send_byte(key_stream.pop_front());
        wait_chars_done();

        gap_max   = 0;
        burst_max = 40;
        run_phase(250);
        wait_chars_done();

        // receiver holds off while bytes keep coming
        rx_mode   = RX_RANDOM;
        rx_hold   = 150;
        gap_max   = 0;
        burst_max = 60;
        run_phase(250);
        wait_chars_done();

        rx_mode   = RX_BURSTY;
        gap_max   = 6;
        burst_max = 8;
        run_phase(350);
        wait_chars_done();

        rx_mode   = RX_RANDOM;
        gap_max   = 3;
        burst_max = 4;
        run_phase(350);
        wait_chars_done();
        repeat (10) @(negedge i_clk);

        if (sb.fail_cnt == 0 && sb.pending() == 0) begin
            $display("scancode_set1_to_ascii_core_tb passed");
        end else begin
            $display("scancode_set1_to_ascii_core_tb failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/scs1_pkg.sv
design/scs1_ifs.sv
design/scancode_set1_to_ascii_core.sv
tb/sv/scancode_set1_to_ascii_core_tb.sv
